>>> rtl/mdpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mdpm_pkg;

  localparam int SAMPLE_BITS = 8;
  localparam int DUTY_W      = 8;
  localparam int FILT_W      = 8;
  localparam int FAULT_W     = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 8;
  localparam int HIST_DEPTH  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_START_DUTY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_STEP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MAX   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLT_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CURR_LIMIT = 3'd5;

  localparam logic [FAULT_W-1:0] FAULT_NONE = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_VOLT = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_TEMP = 2'd2;
  localparam logic [FAULT_W-1:0] FAULT_CURR = 2'd3;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] volt_sample;
    logic [SAMPLE_BITS-1:0] curr_sample;
    logic [SAMPLE_BITS-1:0] temp_sample;
    logic                   start_pressed;
    logic                   minus_pressed;
    logic                   plus_pressed;
    logic                   prime;
  } in_word_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty;
    logic [FAULT_W-1:0] fault_code;
    logic [FILT_W-1:0]  volt_filtered;
    logic [FILT_W-1:0]  curr_filtered;
    logic [FILT_W-1:0]  temp_filtered;
  } out_word_t;

  typedef struct packed {
    logic [DUTY_W-1:0] start_duty;
    logic [DUTY_W-1:0] duty_step;
    logic [DUTY_W-1:0] duty_max;
    logic [FILT_W-1:0] volt_limit;
    logic [FILT_W-1:0] temp_limit;
    logic [FILT_W-1:0] curr_limit;
  } cfg_regs_t;

  typedef struct packed {
    logic [FILT_W-1:0] volt;
    logic [FILT_W-1:0] curr;
    logic [FILT_W-1:0] temp;
  } filt_set_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty;
    logic [FAULT_W-1:0] fault_code;
    logic               held;
  } ctrl_stat_t;

endpackage
`default_nettype wire

>>> rtl/motor_drive_protection_monitor_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Motor drive protection monitor.
// Input channel (in_valid / in_stall / in_word): one word per sample set with raw
// voltage, current and temperature counts plus start, minus, plus and prime bits.
// Result channel (out_valid / out_stall / out_word): exactly one word per input
// word with duty, fault code and the three averaged channel values.
// Config port (cfg_we / cfg_idx / cfg_wdata): write-only, one register per cycle,
// to be used only while no word is in flight.
// Three averaging lanes run side by side, one per channel; a control stage merges
// their outputs into button handling, duty saturation and fault latching.
// Each result is built combinationally from the accepted word and registered in out_r
// (or skid_r). Throughput: 1 word per cycle while in_stall is low.
// When the receiver stalls, the output register holds its word and a one-entry
// skid register takes one more; in_stall rises only when the skid is full.
// Reset (rst_n low, synchronous) clears filter history, duty, drive state, fault,
// both output buffers, and loads default config values.
// After a fault latches, every word returns duty 0, the fault code and frozen
// averages until reset.
module motor_drive_protection_monitor_unit
  import mdpm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_word_t              in_word,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_word_t                  out_word,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_regs_t  cfg_r;
  filt_set_t  filt;
  ctrl_stat_t stat;
  out_word_t  res;
  out_word_t  out_r, out_nxt, skid_r, skid_nxt;
  logic       out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  logic       in_acc, out_take, lane_upd;

  assign in_acc   = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;
  assign lane_upd = in_acc && !stat.held;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_duty <= 8'd80;
      cfg_r.duty_step  <= 8'd10;
      cfg_r.duty_max   <= 8'd100;
      cfg_r.volt_limit <= 8'd217;
      cfg_r.temp_limit <= 8'd168;
      cfg_r.curr_limit <= 8'd61;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_START_DUTY: cfg_r.start_duty <= cfg_wdata;
        CFG_DUTY_STEP:  cfg_r.duty_step  <= cfg_wdata;
        CFG_DUTY_MAX:   cfg_r.duty_max   <= cfg_wdata;
        CFG_VOLT_LIMIT: cfg_r.volt_limit <= cfg_wdata;
        CFG_TEMP_LIMIT: cfg_r.temp_limit <= cfg_wdata;
        CFG_CURR_LIMIT: cfg_r.curr_limit <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mdpm_avg_lane u_lane_volt (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd    (lane_upd),
    .sample (in_word.volt_sample),
    .filt   (filt.volt)
  );

  mdpm_avg_lane u_lane_curr (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd    (lane_upd),
    .sample (in_word.curr_sample),
    .filt   (filt.curr)
  );

  mdpm_avg_lane u_lane_temp (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd    (lane_upd),
    .sample (in_word.temp_sample),
    .filt   (filt.temp)
  );

  mdpm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (in_acc),
    .in_word (in_word),
    .cfg     (cfg_r),
    .filt    (filt),
    .stat    (stat)
  );

  assign res.duty          = stat.duty;
  assign res.fault_code    = stat.fault_code;
  assign res.volt_filtered = filt.volt;
  assign res.curr_filtered = filt.curr;
  assign res.temp_filtered = filt.temp;

  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_take;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (out_take) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else if (in_acc) begin
      if (out_valid_r && !out_take) begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end else begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule
`default_nettype wire

>>> rtl/mdpm_avg_lane.sv
`timescale 1ns / 1ps
`default_nettype none
module mdpm_avg_lane
  import mdpm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   upd,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  output logic      [FILT_W-1:0]      filt
);

  localparam int SUM_W = SAMPLE_BITS + 2;

  logic [FILT_W-1:0] hist_r [HIST_DEPTH];
  logic [SUM_W-1:0]  sum;
  logic [FILT_W-1:0] avg;

  assign sum = SUM_W'(sample) + SUM_W'(hist_r[0]) + SUM_W'(hist_r[1]) + SUM_W'(hist_r[2]);
  assign avg = sum[FILT_W+1:2];
  assign filt = upd ? avg : hist_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HIST_DEPTH; i++) hist_r[i] <= '0;
    end else if (upd) begin
      hist_r[0] <= avg;
      hist_r[1] <= hist_r[0];
      hist_r[2] <= hist_r[1];
    end
  end

endmodule
`default_nettype wire

>>> rtl/mdpm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module mdpm_ctrl
  import mdpm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      acc,
  input  wire in_word_t  in_word,
  input  wire cfg_regs_t cfg,
  input  wire filt_set_t filt,
  output ctrl_stat_t     stat
);

  logic               drive_on_r, drive_on_nxt;
  logic [DUTY_W-1:0]  duty_r, duty_nxt;
  logic [FAULT_W-1:0] fault_r, fault_nxt;
  logic [DUTY_W:0]    plus_sum;
  logic               upd;

  assign upd      = acc && (fault_r == FAULT_NONE) && !in_word.prime;
  assign plus_sum = {1'b0, duty_r} + {1'b0, cfg.duty_step};

  always_comb begin
    drive_on_nxt = drive_on_r;
    duty_nxt     = duty_r;
    fault_nxt    = fault_r;
    if (upd) begin
      if (in_word.start_pressed) begin
        drive_on_nxt = !drive_on_r;
        duty_nxt     = drive_on_r ? '0 : cfg.start_duty;
      end else if (in_word.minus_pressed) begin
        duty_nxt = (duty_r >= cfg.duty_step) ? duty_r - cfg.duty_step : '0;
      end else if (in_word.plus_pressed) begin
        duty_nxt = (plus_sum > {1'b0, cfg.duty_max}) ? cfg.duty_max : plus_sum[DUTY_W-1:0];
      end
      if (filt.volt > cfg.volt_limit) begin
        fault_nxt = FAULT_VOLT;
      end else if (filt.temp > cfg.temp_limit) begin
        fault_nxt = FAULT_TEMP;
      end else if (filt.curr > cfg.curr_limit) begin
        fault_nxt = FAULT_CURR;
      end
      if (fault_nxt != FAULT_NONE) begin
        duty_nxt     = '0;
        drive_on_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_on_r <= 1'b0;
      duty_r     <= '0;
      fault_r    <= FAULT_NONE;
    end else begin
      drive_on_r <= drive_on_nxt;
      duty_r     <= duty_nxt;
      fault_r    <= fault_nxt;
    end
  end

  assign stat.duty       = duty_nxt;
  assign stat.fault_code = fault_nxt;
  assign stat.held       = (fault_r != FAULT_NONE);

endmodule
`default_nettype wire

>>> rtl/mdpm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module mdpm_checker
  import mdpm_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_word_t out_word
);

  a_fault_zero_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.fault_code != FAULT_NONE) |-> (out_word.duty == '0))
    else $error("fault word with nonzero duty");

  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output register");

  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid && !in_stall)
    else $error("buffers not empty after reset");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_word_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_word))
    else $error("out_word changed while stalled");

endmodule

bind motor_drive_protection_monitor_unit mdpm_checker u_mdpm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import mdpm_pkg::*;

  localparam int VOLT_CH = 0;
  localparam int CURR_CH = 1;
  localparam int TEMP_CH = 2;
  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_LIMIT = 10;
  // indexes past the register list; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  class drive_status_board;
    cfg_regs_t regs;
    logic [FILT_W-1:0] hist[3][HIST_DEPTH];
    logic drive_on;
    logic [DUTY_W-1:0] duty;
    logic [FAULT_W-1:0] fault;
    out_word_t expected_status[$];
    int mismatch_count;

    function new();
      regs.start_duty = 8'd80;
      regs.duty_step  = 8'd10;
      regs.duty_max   = 8'd100;
      regs.volt_limit = 8'd217;
      regs.temp_limit = 8'd168;
      regs.curr_limit = 8'd61;
      foreach (hist[i, j]) hist[i][j] = '0;
      drive_on = 1'b0;
      duty = '0;
      fault = FAULT_NONE;
      mismatch_count = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_START_DUTY: regs.start_duty = val;
        CFG_DUTY_STEP:  regs.duty_step  = val;
        CFG_DUTY_MAX:   regs.duty_max   = val;
        CFG_VOLT_LIMIT: regs.volt_limit = val;
        CFG_TEMP_LIMIT: regs.temp_limit = val;
        CFG_CURR_LIMIT: regs.curr_limit = val;
        default: ;
      endcase
    endfunction

    function logic [FILT_W-1:0] avg_update(int ch, logic [SAMPLE_BITS-1:0] s);
      logic [FILT_W+1:0] sum;
      sum = s + hist[ch][0] + hist[ch][1] + hist[ch][2];
      hist[ch][2] = hist[ch][1];
      hist[ch][1] = hist[ch][0];
      hist[ch][0] = sum[FILT_W+1:2];
      return hist[ch][0];
    endfunction

    function void note_sample_set(in_word_t w);
      logic [FILT_W-1:0] vf, cf, tf;
      logic [DUTY_W:0] sum;
      out_word_t e;
      if (fault == FAULT_NONE) begin
        vf = avg_update(VOLT_CH, w.volt_sample);
        cf = avg_update(CURR_CH, w.curr_sample);
        tf = avg_update(TEMP_CH, w.temp_sample);
        if (!w.prime) begin
          if (w.start_pressed) begin
            if (!drive_on) begin
              duty = regs.start_duty;
              drive_on = 1'b1;
            end else begin
              duty = '0;
              drive_on = 1'b0;
            end
          end else if (w.minus_pressed) begin
            duty = (duty >= regs.duty_step) ? duty - regs.duty_step : '0;
          end else if (w.plus_pressed) begin
            sum = duty + regs.duty_step;
            duty = (sum > regs.duty_max) ? regs.duty_max : sum[DUTY_W-1:0];
          end
          if (vf > regs.volt_limit) fault = FAULT_VOLT;
          else if (tf > regs.temp_limit) fault = FAULT_TEMP;
          else if (cf > regs.curr_limit) fault = FAULT_CURR;
          if (fault != FAULT_NONE) begin
            duty = '0;
            drive_on = 1'b0;
          end
        end
      end
      e.duty = duty;
      e.fault_code = fault;
      e.volt_filtered = hist[VOLT_CH][0];
      e.curr_filtered = hist[CURR_CH][0];
      e.temp_filtered = hist[TEMP_CH][0];
      expected_status.push_back(e);
    endfunction

    function void check_status(out_word_t got);
      out_word_t e;
      string bad;
      if (expected_status.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected status word: duty=%0d fault=%0d v=%0d c=%0d t=%0d",
                   got.duty, got.fault_code, got.volt_filtered, got.curr_filtered,
                   got.temp_filtered);
        return;
      end
      e = expected_status.pop_front();
      bad = "";
      if (got.duty !== e.duty) bad = {bad, " duty"};
      if (got.fault_code !== e.fault_code) bad = {bad, " fault_code"};
      if (got.volt_filtered !== e.volt_filtered) bad = {bad, " volt_filtered"};
      if (got.curr_filtered !== e.curr_filtered) bad = {bad, " curr_filtered"};
      if (got.temp_filtered !== e.temp_filtered) bad = {bad, " temp_filtered"};
      if (bad != "") begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("status mismatch (%s ) at %0t:", bad, $realtime);
          $display("  exp duty=%0d fault=%0d v=%0d c=%0d t=%0d",
                   e.duty, e.fault_code, e.volt_filtered, e.curr_filtered,
                   e.temp_filtered);
          $display("  got duty=%0d fault=%0d v=%0d c=%0d t=%0d",
                   got.duty, got.fault_code, got.volt_filtered, got.curr_filtered,
                   got.temp_filtered);
        end
      end
    endfunction

    function int pending();
      return expected_status.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_word_t in_word;
  logic out_valid;
  logic out_stall;
  out_word_t out_word;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  drive_status_board sb;
  bit quiet;
  int gap_pct;
  int stall_pct;
  int cycle_count = 0;

  motor_drive_protection_monitor_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_status(out_word);
      if (in_valid && !in_stall) sb.note_sample_set(in_word);
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && !quiet && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_word_t sample_set(logic [7:0] v, logic [7:0] c, logic [7:0] t,
                                          bit st, bit mi, bit pl, bit pr);
    in_word_t w;
    w.volt_sample = v;
    w.curr_sample = c;
    w.temp_sample = t;
    w.start_pressed = st;
    w.minus_pressed = mi;
    w.plus_pressed = pl;
    w.prime = pr;
    return w;
  endfunction

  function automatic in_word_t random_set();
    return sample_set(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), $urandom_range(0, 2) == 0,
                      $urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0,
                      $urandom_range(0, 4) == 0);
  endfunction

  function automatic in_word_t low_set(bit st, bit mi, bit pl, bit pr);
    return sample_set(8'($urandom_range(0, 40)), 8'($urandom_range(0, 40)),
                      8'($urandom_range(0, 40)), st, mi, pl, pr);
  endfunction

  function automatic logic [7:0] pick_limit();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(60, 250));
    endcase
  endfunction

  // leaves valid high unless a random gap is drawn, so back-to-back words need no idle time
  task automatic send_word(in_word_t w);
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // leaves the write enable high; load_cfg lowers it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic load_cfg(logic [7:0] sd, logic [7:0] st, logic [7:0] mx,
                          logic [7:0] vl, logic [7:0] tl, logic [7:0] cl);
    write_reg(CFG_START_DUTY, sd);
    write_reg(CFG_DUTY_STEP, st);
    write_reg(CFG_DUTY_MAX, mx);
    write_reg(CFG_VOLT_LIMIT, vl);
    write_reg(CFG_TEMP_LIMIT, tl);
    write_reg(CFG_CURR_LIMIT, cl);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int n);
    repeat (n) send_word(random_set());
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    quiet = 1'b0;
    gap_pct = 0;
    stall_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config, low samples so no limit trips
    gap_pct = 20;
    stall_pct = 20;
    send_word(low_set(0, 0, 0, 1));
    send_word(low_set(1, 0, 0, 0));
    send_word(low_set(0, 0, 1, 0));
    send_word(low_set(0, 0, 1, 0));
    send_word(low_set(0, 0, 1, 0));
    send_word(low_set(0, 1, 0, 0));
    send_word(low_set(1, 1, 1, 0));
    send_word(low_set(0, 1, 0, 0));
    send_word(low_set(0, 1, 1, 0));
    send_word(low_set(0, 0, 1, 0));
    send_word(low_set(1, 0, 0, 0));
    send_word(low_set(1, 1, 1, 1));
    wait_all_results();

    // register extremes, limits out of reach
    write_reg(CFG_SPARE_A, 8'hff);
    write_reg(CFG_SPARE_B, 8'h00);
    load_cfg(8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255);
    send_word(sample_set(8'd255, 8'd255, 8'd255, 1, 0, 0, 0));
    send_word(sample_set(8'd255, 8'd255, 8'd255, 1, 0, 0, 0));
    send_word(sample_set(8'd0, 8'd0, 8'd0, 0, 0, 1, 0));
    send_word(sample_set(8'd255, 8'd0, 8'd255, 1, 0, 0, 0));
    send_word(sample_set(8'd0, 8'd255, 8'd0, 1, 0, 0, 0));
    send_word(sample_set(8'd255, 8'd255, 8'd255, 0, 1, 0, 0));
    send_word(sample_set(8'd0, 8'd0, 8'd0, 0, 0, 1, 1));
    send_word(sample_set(8'd255, 8'd255, 8'd255, 0, 0, 1, 0));
    wait_all_results();

    gap_pct = 30;
    stall_pct = 30;
    load_cfg(8'($urandom_range(0, 255)), 8'($urandom_range(0, 40)),
             8'($urandom_range(0, 255)), 8'd255, 8'd255, 8'd255);
    run_random(80);
    wait_all_results();

    gap_pct = 0;
    stall_pct = 0;
    load_cfg(8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255);
    run_random(30);
    wait_all_results();
    run_random(30);
    wait_all_results();

    gap_pct = 50;
    stall_pct = 50;
    load_cfg(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)), 8'd255, 8'd255, 8'd255);
    run_random(80);
    wait_all_results();

    gap_pct = 10;
    stall_pct = 10;
    load_cfg(8'd255, 8'd1, 8'd255, 8'd255, 8'd255, 8'd255);
    run_random(60);
    wait_all_results();

    // live limits: once a fault latches, the block holds from then on
    quiet = 1'b1;
    load_cfg(8'($urandom_range(0, 255)), 8'($urandom_range(0, 60)),
             8'($urandom_range(0, 255)), pick_limit(), pick_limit(), pick_limit());
    run_random(80);
    wait_all_results();
    repeat (5) @(posedge clk);

    if (sb.mismatch_count == 0 && sb.pending() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
